### rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge
`define PSODU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// cond must never be true
`define PSODU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/psodu_pkg.sv
// -----------------------------------------------------------------------------
// psodu_pkg
// Types and constants shared by the particle dimension update pipeline.
// -----------------------------------------------------------------------------
package psodu_pkg;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    CfgInertiaStart = 3'd0,
    CfgInertiaEnd   = 3'd1,
    CfgMaxIter      = 3'd2,
    CfgCognGain     = 3'd3,
    CfgSocGain      = 3'd4,
    CfgStepScale    = 3'd5,
    CfgLowerLimit   = 3'd6,
    CfgUpperLimit   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActReseed = 2'd1,
    ActShrink = 2'd2,
    ActClamp  = 2'd3
  } bound_act_e;

  localparam int unsigned CfgAddrW = 5;

  localparam logic [30:0]        RstInertiaStart = 31'd58982;
  localparam logic [30:0]        RstInertiaEnd   = 31'd26214;
  localparam logic [15:0]        RstMaxIter      = 16'd100;
  localparam logic [30:0]        RstCognGain     = 31'd131072;
  localparam logic [30:0]        RstSocGain      = 31'd131072;
  localparam logic [30:0]        RstStepScale    = 31'd65536;
  localparam logic signed [31:0] RstLowerLimit   = 32'sh8000_0000;
  localparam logic signed [31:0] RstUpperLimit   = 32'sh7FFF_FFFF;

  // schedule divider: 32 quotient bits, two per stage
  localparam int unsigned DivBits      = 32;
  localparam int unsigned DivRadixBits = 2;
  localparam int unsigned DivStages    = DivBits / DivRadixBits;

  // accept to result, in clock edges
  localparam int unsigned Latency = DivStages + 8;

  // item fields that ride alongside the schedule divider
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] v;
    logic        [15:0] rb;
    logic               clamp;
    logic signed [48:0] gsum;
  } side_t;

endpackage

### rtl/psodu_wdiv.sv
// -----------------------------------------------------------------------------
// psodu_wdiv
// Pipelined restoring divider for the inertia schedule: 63-bit dividend over a
// 32-bit divisor, two quotient bits per stage, result capped at 2^32.
// -----------------------------------------------------------------------------
module psodu_wdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [62:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  input  psodu_pkg::side_t    side_i,
  output logic                valid_o,
  output logic [32:0]         quot_o,
  output psodu_pkg::side_t    side_o
);

`include "assert_macros.svh"

  localparam int unsigned Stg = psodu_pkg::DivStages;

  logic [Stg:0]     vld_q;
  logic [Stg:0]     ovf_q;
  logic [31:0]      rem_q  [Stg+1];
  logic [31:0]      low_q  [Stg+1];
  logic [31:0]      quo_q  [Stg+1];
  psodu_pkg::side_t side_q [Stg+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  // quotient of 2^32 or more saturates the weight anyway
  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= ({1'b0, dividend_i[62:32]} >= divisor_i);
    rem_q[0]  <= {1'b0, dividend_i[62:32]};
    low_q[0]  <= dividend_i[31:0];
    quo_q[0]  <= '0;
    side_q[0] <= side_i;
  end

  for (genvar k = 0; k < Stg; k++) begin : g_stage
    logic [32:0] trial;
    logic [31:0] rem_d;
    logic [31:0] low_d;
    logic [31:0] quo_d;

    always_comb begin
      rem_d = rem_q[k];
      low_d = low_q[k];
      quo_d = quo_q[k];
      trial = '0;
      for (int b = 0; b < int'(psodu_pkg::DivRadixBits); b++) begin
        trial = {rem_d, low_d[31]};
        low_d = {low_d[30:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = 32'(trial - {1'b0, divisor_i});
          quo_d = {quo_d[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[k+1]  <= ovf_q[k];
      rem_q[k+1]  <= rem_d;
      low_q[k+1]  <= low_d;
      quo_q[k+1]  <= quo_d;
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[Stg];
  assign quot_o  = ovf_q[Stg] ? {1'b1, 32'd0} : {1'b0, quo_q[Stg]};
  assign side_o  = side_q[Stg];

  `PSODU_ASSERT(a_div_latency, valid_i |-> ##(psodu_pkg::DivStages + 1) valid_o, "divider lost an item")
  `PSODU_ASSERT_NEVER(a_div_rem, valid_o && !ovf_q[Stg] && (rem_q[Stg] >= divisor_i), "divider remainder not reduced")

endmodule

### rtl/pso_particle_dimension_update_top.sv
// -----------------------------------------------------------------------------
// pso_particle_dimension_update_top
// Velocity and position update of one particle dimension, Q16.16, with
// quadratic inertia schedule and re-seed / shrink / clamp bound handling.
// -----------------------------------------------------------------------------
// Channel   Handshake                        Payload
// config    psel & penable & pwrite, pready  paddr, pwdata, prdata
// item in   start & !busy                    position_i .. pick_clamp_i
// result    done_o, one cycle                new_position_o, new_velocity_o,
//                                            bound_action_o
//
// One item per cycle; busy stays low. A taken item passes multiply / add stages
// A and B, the 16 radix-4 stages of the inertia schedule divider, then stages
// W, M1, M2, M3 and the output stage. Reset clears the valid pipeline and loads
// the register defaults. Results cannot be held off by the receiver.
// -----------------------------------------------------------------------------
module pso_particle_dimension_update_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // item in
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  position_i,
  input  logic signed [31:0]  velocity_i,
  input  logic signed [31:0]  personal_best_i,
  input  logic signed [31:0]  global_best_i,
  input  logic [15:0]         iteration_i,
  input  logic [15:0]         rand_cognitive_i,
  input  logic [15:0]         rand_social_i,
  input  logic [15:0]         rand_bound_i,
  input  logic                pick_clamp_i,
  // result
  output logic                done_o,
  output logic signed [31:0]  new_position_o,
  output logic signed [31:0]  new_velocity_o,
  output logic [1:0]          bound_action_o
);

`include "assert_macros.svh"

  localparam logic signed [49:0] SatMax = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [49:0] SatMin = -SatMax - 50'sd1;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
    logic signed [31:0] r;
    if (a > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (a < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [30:0]        inertia_start_q, inertia_end_q;
  logic [15:0]        max_iterations_q;
  logic [30:0]        cognitive_gain_q, social_gain_q, step_scale_q;
  logic signed [31:0] lower_limit_q, upper_limit_q;
  psodu_pkg::cfg_idx_e cfg_idx;
  logic               cfg_we;

  assign cfg_idx = psodu_pkg::cfg_idx_e'(paddr[psodu_pkg::CfgAddrW-1:2]);
  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inertia_start_q  <= psodu_pkg::RstInertiaStart;
      inertia_end_q    <= psodu_pkg::RstInertiaEnd;
      max_iterations_q <= psodu_pkg::RstMaxIter;
      cognitive_gain_q <= psodu_pkg::RstCognGain;
      social_gain_q    <= psodu_pkg::RstSocGain;
      step_scale_q     <= psodu_pkg::RstStepScale;
      lower_limit_q    <= psodu_pkg::RstLowerLimit;
      upper_limit_q    <= psodu_pkg::RstUpperLimit;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        psodu_pkg::CfgInertiaStart: inertia_start_q  <= pwdata[30:0];
        psodu_pkg::CfgInertiaEnd:   inertia_end_q    <= pwdata[30:0];
        psodu_pkg::CfgMaxIter:      max_iterations_q <= pwdata[15:0];
        psodu_pkg::CfgCognGain:     cognitive_gain_q <= pwdata[30:0];
        psodu_pkg::CfgSocGain:      social_gain_q    <= pwdata[30:0];
        psodu_pkg::CfgStepScale:    step_scale_q     <= pwdata[30:0];
        psodu_pkg::CfgLowerLimit:   lower_limit_q    <= pwdata;
        psodu_pkg::CfgUpperLimit:   upper_limit_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      psodu_pkg::CfgInertiaStart: prdata = {1'b0, inertia_start_q};
      psodu_pkg::CfgInertiaEnd:   prdata = {1'b0, inertia_end_q};
      psodu_pkg::CfgMaxIter:      prdata = {16'd0, max_iterations_q};
      psodu_pkg::CfgCognGain:     prdata = {1'b0, cognitive_gain_q};
      psodu_pkg::CfgSocGain:      prdata = {1'b0, social_gain_q};
      psodu_pkg::CfgStepScale:    prdata = {1'b0, step_scale_q};
      psodu_pkg::CfgLowerLimit:   prdata = lower_limit_q;
      psodu_pkg::CfgUpperLimit:   prdata = upper_limit_q;
      default:                    prdata = '0;
    endcase
  end

  // schedule constants, refreshed every cycle from the registers
  logic [31:0] sched_d;
  logic [15:0] mx_eff;
  logic [30:0] absd_q;
  logic        dneg_q;
  logic [31:0] mx2_q;

  assign sched_d = {1'b0, inertia_start_q} - {1'b0, inertia_end_q};
  assign mx_eff  = (max_iterations_q == 16'd0) ? 16'd1 : max_iterations_q;

  always_ff @(posedge clk_i) begin
    dneg_q <= sched_d[31];
    absd_q <= sched_d[31] ? 31'(-sched_d) : sched_d[30:0];
    mx2_q  <= {16'd0, mx_eff} * {16'd0, mx_eff};
  end

  // ---------------------------------------------------------------------------
  // Stage A: squares, random gains, best-position offsets
  // ---------------------------------------------------------------------------
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic [46:0] g1_prod, g2_prod;
  assign g1_prod = 47'(cognitive_gain_q) * 47'(rand_cognitive_i);
  assign g2_prod = 47'(social_gain_q) * 47'(rand_social_i);

  logic               a_vld_q;
  logic signed [31:0] a_x_q, a_v_q;
  logic [15:0]        a_rb_q;
  logic               a_clamp_q;
  logic [31:0]        a_iter2_q;
  logic [30:0]        a_g1_q, a_g2_q;
  logic signed [32:0] a_dp_q, a_dg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_x_q     <= position_i;
    a_v_q     <= velocity_i;
    a_rb_q    <= rand_bound_i;
    a_clamp_q <= pick_clamp_i;
    a_iter2_q <= {16'd0, iteration_i} * {16'd0, iteration_i};
    a_g1_q    <= g1_prod[46:16];
    a_g2_q    <= g2_prod[46:16];
    a_dp_q    <= 33'(personal_best_i) - 33'(position_i);
    a_dg_q    <= 33'(global_best_i) - 33'(position_i);
  end

  // ---------------------------------------------------------------------------
  // Stage B: schedule numerator, cognitive and social terms
  // ---------------------------------------------------------------------------
  logic signed [63:0] t2_prod, t3_prod;
  assign t2_prod = 64'($signed({1'b0, a_g1_q})) * 64'(a_dp_q);
  assign t3_prod = 64'($signed({1'b0, a_g2_q})) * 64'(a_dg_q);

  logic               b_vld_q;
  logic [62:0]        b_n_q;
  logic signed [47:0] b_t2_q, b_t3_q;
  logic signed [31:0] b_x_q, b_v_q;
  logic [15:0]        b_rb_q;
  logic               b_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_n_q     <= 63'(absd_q) * 63'(a_iter2_q);
    b_t2_q    <= t2_prod[63:16];
    b_t3_q    <= t3_prod[63:16];
    b_x_q     <= a_x_q;
    b_v_q     <= a_v_q;
    b_rb_q    <= a_rb_q;
    b_clamp_q <= a_clamp_q;
  end

  // ---------------------------------------------------------------------------
  // Schedule divider
  // ---------------------------------------------------------------------------
  psodu_pkg::side_t side_in, side_out;
  logic             dv_vld;
  logic [32:0]      dv_quot;

  always_comb begin
    side_in.x     = b_x_q;
    side_in.v     = b_v_q;
    side_in.rb    = b_rb_q;
    side_in.clamp = b_clamp_q;
    side_in.gsum  = 49'(b_t2_q) + 49'(b_t3_q);
  end

  psodu_wdiv u_wdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_vld_q),
    .dividend_i (b_n_q),
    .divisor_i  (mx2_q),
    .side_i     (side_in),
    .valid_o    (dv_vld),
    .quot_o     (dv_quot),
    .side_o     (side_out)
  );

  // ---------------------------------------------------------------------------
  // Stage W: inertia weight, limit offsets
  // ---------------------------------------------------------------------------
  logic [33:0]        start_x;
  logic signed [33:0] w_full;
  assign start_x = {3'd0, inertia_start_q};
  assign w_full  = dneg_q ? $signed(start_x + {1'b0, dv_quot})
                          : $signed(start_x - {1'b0, dv_quot});

  logic               w_vld_q;
  logic signed [31:0] w_q, w_x_q, w_v_q;
  logic [15:0]        w_rb_q;
  logic               w_clamp_q;
  logic signed [48:0] w_gsum_q;
  logic signed [32:0] w_ulmx_q, w_llmx_q, w_xmll_q, w_rng_q;
  logic               w_eqhi_q, w_eqlo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
    end else begin
      w_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= sat32(50'(w_full));
    w_x_q     <= side_out.x;
    w_v_q     <= side_out.v;
    w_rb_q    <= side_out.rb;
    w_clamp_q <= side_out.clamp;
    w_gsum_q  <= side_out.gsum;
    w_ulmx_q  <= 33'(upper_limit_q) - 33'(side_out.x);
    w_llmx_q  <= 33'(lower_limit_q) - 33'(side_out.x);
    w_xmll_q  <= 33'(side_out.x) - 33'(lower_limit_q);
    w_rng_q   <= 33'(upper_limit_q) - 33'(lower_limit_q);
    w_eqhi_q  <= (side_out.x == upper_limit_q);
    w_eqlo_q  <= (side_out.x == lower_limit_q);
  end

  // ---------------------------------------------------------------------------
  // Stage M1: inertia term, bound products
  // ---------------------------------------------------------------------------
  logic signed [63:0] t1_prod;
  logic signed [16:0] rb_s;
  assign t1_prod = 64'(w_q) * 64'(w_v_q);
  assign rb_s    = $signed({1'b0, w_rb_q});

  logic               m1_vld_q;
  logic signed [47:0] m1_t1_q;
  logic signed [48:0] m1_gsum_q;
  logic signed [31:0] m1_x_q;
  logic signed [49:0] m1_prs_q, m1_phi_q, m1_plo_q;
  logic signed [32:0] m1_ulmx_q, m1_llmx_q;
  logic               m1_eqhi_q, m1_eqlo_q, m1_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= w_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_t1_q    <= t1_prod[63:16];
    m1_gsum_q  <= w_gsum_q;
    m1_x_q     <= w_x_q;
    m1_prs_q   <= 50'(rb_s) * 50'(w_rng_q);
    m1_phi_q   <= 50'(w_ulmx_q) * 50'(rb_s);
    m1_plo_q   <= 50'(w_xmll_q) * 50'(rb_s);
    m1_ulmx_q  <= w_ulmx_q;
    m1_llmx_q  <= w_llmx_q;
    m1_eqhi_q  <= w_eqhi_q;
    m1_eqlo_q  <= w_eqlo_q;
    m1_clamp_q <= w_clamp_q;
  end

  // ---------------------------------------------------------------------------
  // Stage M2: new velocity, bound candidates
  // ---------------------------------------------------------------------------
  logic               m2_vld_q;
  logic signed [31:0] m2_nv_q, m2_x_q;
  logic signed [34:0] m2_crs_q, m2_chi_q, m2_clo_q;
  logic signed [32:0] m2_ulmx_q, m2_llmx_q;
  logic               m2_eqhi_q, m2_eqlo_q, m2_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_nv_q    <= sat32(50'(m1_t1_q) + 50'(m1_gsum_q));
    m2_x_q     <= m1_x_q;
    m2_crs_q   <= 35'(lower_limit_q) + 35'($signed(m1_prs_q[49:16]));
    m2_chi_q   <= 35'(upper_limit_q) - 35'($signed(m1_phi_q[49:16]));
    m2_clo_q   <= 35'(lower_limit_q) + 35'($signed(m1_plo_q[49:16]));
    m2_ulmx_q  <= m1_ulmx_q;
    m2_llmx_q  <= m1_llmx_q;
    m2_eqhi_q  <= m1_eqhi_q;
    m2_eqlo_q  <= m1_eqlo_q;
    m2_clamp_q <= m1_clamp_q;
  end

  // ---------------------------------------------------------------------------
  // Stage M3: position step, per-side bound choice
  // ---------------------------------------------------------------------------
  logic signed [62:0] sp_prod;
  assign sp_prod = 63'($signed({1'b0, step_scale_q})) * 63'(m2_nv_q);

  logic                  m3_vld_q;
  logic signed [46:0]    m3_sp_q;
  logic signed [31:0]    m3_nv_q, m3_x_q;
  logic signed [32:0]    m3_ulmx_q, m3_llmx_q;
  logic signed [34:0]    m3_bhi_q, m3_blo_q;
  psodu_pkg::bound_act_e m3_ahi_q, m3_alo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m3_sp_q   <= sp_prod[62:16];
    m3_nv_q   <= m2_nv_q;
    m3_x_q    <= m2_x_q;
    m3_ulmx_q <= m2_ulmx_q;
    m3_llmx_q <= m2_llmx_q;
    // old position on the bound: re-seed, else shrink or clamp
    if (m2_eqhi_q) begin
      m3_bhi_q <= m2_crs_q;
      m3_ahi_q <= psodu_pkg::ActReseed;
    end else if (m2_clamp_q) begin
      m3_bhi_q <= 35'(upper_limit_q);
      m3_ahi_q <= psodu_pkg::ActClamp;
    end else begin
      m3_bhi_q <= m2_chi_q;
      m3_ahi_q <= psodu_pkg::ActShrink;
    end
    if (m2_eqlo_q) begin
      m3_blo_q <= m2_crs_q;
      m3_alo_q <= psodu_pkg::ActReseed;
    end else if (m2_clamp_q) begin
      m3_blo_q <= 35'(lower_limit_q);
      m3_alo_q <= psodu_pkg::ActClamp;
    end else begin
      m3_blo_q <= m2_clo_q;
      m3_alo_q <= psodu_pkg::ActShrink;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: bound tests, select, saturate
  // ---------------------------------------------------------------------------
  logic signed [47:0]    p_full;
  logic                  over_hi, under_lo;
  logic signed [49:0]    p_sel;
  psodu_pkg::bound_act_e act_sel;

  assign p_full   = 48'(m3_x_q) + 48'(m3_sp_q);
  // p > upper  <=>  step > upper - x, same for the lower side
  assign over_hi  = 48'(m3_sp_q) > 48'(m3_ulmx_q);
  assign under_lo = 48'(m3_sp_q) < 48'(m3_llmx_q);

  always_comb begin
    if (over_hi) begin
      p_sel   = 50'(m3_bhi_q);
      act_sel = m3_ahi_q;
    end else if (under_lo) begin
      p_sel   = 50'(m3_blo_q);
      act_sel = m3_alo_q;
    end else begin
      p_sel   = 50'(p_full);
      act_sel = psodu_pkg::ActNone;
    end
  end

  logic                  out_vld_q;
  logic signed [31:0]    out_pos_q, out_vel_q;
  psodu_pkg::bound_act_e out_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q <= sat32(p_sel);
    out_vel_q <= m3_nv_q;
    out_act_q <= act_sel;
  end

  assign done_o         = out_vld_q;
  assign new_position_o = out_pos_q;
  assign new_velocity_o = out_vel_q;
  assign bound_action_o = out_act_q;

  `PSODU_ASSERT(a_item_latency, start && !busy |-> ##(psodu_pkg::Latency) done_o, "item result missing")
  `PSODU_ASSERT(a_clamp_on_limit, done_o && (out_act_q == psodu_pkg::ActClamp) |-> (new_position_o == lower_limit_q) || (new_position_o == upper_limit_q), "clamped position off the limits")
  `PSODU_ASSERT(a_free_in_range, done_o && (out_act_q == psodu_pkg::ActNone) |-> (new_position_o >= lower_limit_q) && (new_position_o <= upper_limit_q), "unbounded position outside limits")

endmodule

### dv/pso_particle_dimension_update_top_tb.sv
// -----------------------------------------------------------------------------
// pso_particle_dimension_update_top_tb
// Self-checking bench for the particle dimension update. Registers go in over
// the APB port and are read back; items are streamed in bursts, and every
// result is compared with a table value or a bit-exact Q16.16 model of the
// velocity, position and bound rules. A directed table comes first, then
// random register settings with mostly in-range particles and some raw noise.
// -----------------------------------------------------------------------------
module pso_particle_dimension_update_top_tb;
  import psodu_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] pbest;
    logic [31:0] gbest;
    logic [15:0] iter;
    logic [15:0] rc;
    logic [15:0] rs;
    logic [15:0] rb;
    logic        clamp;
  } upd_item_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    bound_act_e  act;
  } upd_res_t;

  typedef struct packed {
    logic [2:0] set;
    upd_item_t  it;
    logic       has_exp;
    upd_res_t   res;
  } dir_row_t;

  typedef logic [7:0][31:0] reg_set_t;

  localparam int          NumRegs = 8;
  localparam logic [31:0] PosMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] PosMin  = 32'h8000_0000;
  localparam wide_t       QMax    = 80'sd2147483647;
  localparam wide_t       QMin    = -80'sd2147483648;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic signed [31:0] position_i = '0;
  logic signed [31:0] velocity_i = '0;
  logic signed [31:0] personal_best_i = '0;
  logic signed [31:0] global_best_i = '0;
  logic [15:0] iteration_i = '0;
  logic [15:0] rand_cognitive_i = '0;
  logic [15:0] rand_social_i = '0;
  logic [15:0] rand_bound_i = '0;
  logic        pick_clamp_i = 1'b0;
  logic        done_o;
  logic signed [31:0] new_position_o;
  logic signed [31:0] new_velocity_o;
  logic [1:0]  bound_action_o;

  // register copy used by the predictor
  logic [30:0]        cfg_start = RstInertiaStart;
  logic [30:0]        cfg_end   = RstInertiaEnd;
  logic [15:0]        cfg_maxit = RstMaxIter;
  logic [30:0]        cfg_cogn  = RstCognGain;
  logic [30:0]        cfg_soc   = RstSocGain;
  logic [30:0]        cfg_step  = RstStepScale;
  logic signed [31:0] cfg_lo    = RstLowerLimit;
  logic signed [31:0] cfg_hi    = RstUpperLimit;

  upd_res_t exp_updates[$];
  dir_row_t dir_rows[$];
  reg_set_t dir_set[5];
  int n_items = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int act_seen[4];
  int burst_left = 0;
  logic idle_on = 1'b1;

  pso_particle_dimension_update_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .position_i       (position_i),
    .velocity_i       (velocity_i),
    .personal_best_i  (personal_best_i),
    .global_best_i    (global_best_i),
    .iteration_i      (iteration_i),
    .rand_cognitive_i (rand_cognitive_i),
    .rand_social_i    (rand_social_i),
    .rand_bound_i     (rand_bound_i),
    .pick_clamp_i     (pick_clamp_i),
    .done_o           (done_o),
    .new_position_o   (new_position_o),
    .new_velocity_o   (new_velocity_o),
    .bound_action_o   (bound_action_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic wide_t sat_q(wide_t a);
    if (a > QMax) return QMax;
    if (a < QMin) return QMin;
    return a;
  endfunction

  // bit-exact update; products floor-shifted by 16, schedule quotient truncated
  function automatic upd_res_t predict_update(upd_item_t it);
    wide_t x, v, pb, gb, rc, rs, rb, it2, mx, d, dabs, mag, q, w;
    wide_t ws, we, gc, gs, st, g1, g2, nv, p, lo, hi;
    upd_res_t r;
    x  = $signed(it.pos);
    v  = $signed(it.vel);
    pb = $signed(it.pbest);
    gb = $signed(it.gbest);
    rc = it.rc;
    rs = it.rs;
    rb = it.rb;
    ws = cfg_start;
    we = cfg_end;
    gc = cfg_cogn;
    gs = cfg_soc;
    st = cfg_step;
    lo = cfg_lo;
    hi = cfg_hi;
    mx = cfg_maxit;
    if (mx == 0) mx = 1;
    it2 = it.iter;
    it2 = it2 * it2;
    d = ws - we;
    dabs = (d < 0) ? -d : d;
    mag = dabs * it2 / (mx * mx);
    q = (d < 0) ? -mag : mag;
    w = sat_q(ws - q);
    g1 = (gc * rc) >>> 16;
    g2 = (gs * rs) >>> 16;
    nv = ((w * v) >>> 16) + ((g1 * (pb - x)) >>> 16) + ((g2 * (gb - x)) >>> 16);
    nv = sat_q(nv);
    p = x + ((st * nv) >>> 16);
    r.act = ActNone;
    if (p > hi) begin
      if (x == hi) begin
        p = lo + ((rb * (hi - lo)) >>> 16);
        r.act = ActReseed;
      end else if (!it.clamp) begin
        p = hi - (((hi - x) * rb) >>> 16);
        r.act = ActShrink;
      end else begin
        p = hi;
        r.act = ActClamp;
      end
    end else if (p < lo) begin
      if (x == lo) begin
        p = lo + ((rb * (hi - lo)) >>> 16);
        r.act = ActReseed;
      end else if (!it.clamp) begin
        p = lo + (((x - lo) * rb) >>> 16);
        r.act = ActShrink;
      end else begin
        p = lo;
        r.act = ActClamp;
      end
    end
    p = sat_q(p);
    r.pos = p[31:0];
    r.vel = nv[31:0];
    return r;
  endfunction

  function automatic logic [31:0] cfg_value(cfg_idx_e idx);
    case (idx)
      CfgInertiaStart: return {1'b0, cfg_start};
      CfgInertiaEnd:   return {1'b0, cfg_end};
      CfgMaxIter:      return {16'd0, cfg_maxit};
      CfgCognGain:     return {1'b0, cfg_cogn};
      CfgSocGain:      return {1'b0, cfg_soc};
      CfgStepScale:    return {1'b0, cfg_step};
      CfgLowerLimit:   return cfg_lo;
      default:         return cfg_hi;
    endcase
  endfunction

  task automatic cfg_store(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CfgInertiaStart: cfg_start = val[30:0];
      CfgInertiaEnd:   cfg_end   = val[30:0];
      CfgMaxIter:      cfg_maxit = val[15:0];
      CfgCognGain:     cfg_cogn  = val[30:0];
      CfgSocGain:      cfg_soc   = val[30:0];
      CfgStepScale:    cfg_step  = val[30:0];
      CfgLowerLimit:   cfg_lo    = val;
      default:         cfg_hi    = val;
    endcase
  endtask

  // setup then access; returns at the edge that completes the transfer
  task automatic apb_cycle(input logic wr, input cfg_idx_e idx, input logic [31:0] val,
                           output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
  endtask

  task automatic cfg_check_all();
    logic [31:0] rd;
    for (int i = 0; i < NumRegs; i++) begin
      apb_cycle(1'b0, cfg_idx_e'(i), 32'd0, rd);
      if (rd !== cfg_value(cfg_idx_e'(i))) begin
        n_errors++;
        $display("%0t: register %0d read expected %h got %h", $time, i,
                 cfg_value(cfg_idx_e'(i)), rd);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(reg_set_t s);
    logic [31:0] rd;
    for (int i = 0; i < NumRegs; i++) begin
      apb_cycle(1'b1, cfg_idx_e'(i), s[i], rd);
      cfg_store(cfg_idx_e'(i), s[i]);
    end
    cfg_check_all();
    n_settings++;
  endtask

  // block must be idle before its registers change
  task automatic drain_updates();
    start <= 1'b0;
    @(posedge clk_i);
    while (exp_updates.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_update(upd_item_t it, logic has_exp, upd_res_t res);
    start            <= 1'b1;
    position_i       <= it.pos;
    velocity_i       <= it.vel;
    personal_best_i  <= it.pbest;
    global_best_i    <= it.gbest;
    iteration_i      <= it.iter;
    rand_cognitive_i <= it.rc;
    rand_social_i    <= it.rs;
    rand_bound_i     <= it.rb;
    pick_clamp_i     <= it.clamp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_updates.push_back(has_exp ? res : predict_update(it));
    n_items++;
  endtask

  // bursts of random length, gaps long enough to straddle the pipeline
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = !idle_on ? 0 : ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30)
                                                         : $urandom_range(1, 3);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic dir_row_t mk_row(int set, logic [31:0] p, logic [31:0] v,
                                      logic [31:0] pb, logic [31:0] gb, logic [15:0] it,
                                      logic [15:0] rc, logic [15:0] rs, logic [15:0] rb,
                                      logic cl, logic he, logic [31:0] ep, logic [31:0] ev,
                                      bound_act_e ea);
    dir_row_t r;
    r.set      = set[2:0];
    r.it.pos   = p;
    r.it.vel   = v;
    r.it.pbest = pb;
    r.it.gbest = gb;
    r.it.iter  = it;
    r.it.rc    = rc;
    r.it.rs    = rs;
    r.it.rb    = rb;
    r.it.clamp = cl;
    r.has_exp  = he;
    r.res.pos  = ep;
    r.res.vel  = ev;
    r.res.act  = ea;
    return r;
  endfunction

  // in range most of the time, sometimes exactly on a bound
  function automatic logic [31:0] pick_pos();
    longint lo_l, hi_l;
    longint unsigned span, off;
    int sel;
    lo_l = cfg_lo;
    hi_l = cfg_hi;
    sel = $urandom_range(0, 9);
    if (lo_l > hi_l || sel == 0) return $urandom;
    if (sel == 1) return cfg_lo;
    if (sel == 2) return cfg_hi;
    span = hi_l - lo_l;
    off = {$urandom, $urandom} % (span + 1);
    return lo_l + off;
  endfunction

  function automatic upd_item_t gen_item();
    upd_item_t it;
    int sv, mx_i;
    mx_i = cfg_maxit;
    it.rc    = $urandom;
    it.rs    = $urandom;
    it.rb    = $urandom;
    it.clamp = $urandom;
    if ($urandom_range(0, 6) == 0) begin
      it.pos   = $urandom;
      it.vel   = $urandom;
      it.pbest = $urandom;
      it.gbest = $urandom;
      it.iter  = $urandom;
    end else begin
      it.pos   = pick_pos();
      sv       = $urandom;
      it.vel   = sv >>> $urandom_range(0, 31);
      it.pbest = pick_pos();
      it.gbest = pick_pos();
      it.iter  = ($urandom_range(0, 7) == 0) ? $urandom
                                              : $urandom_range(0, mx_i + mx_i / 4);
    end
    return it;
  endfunction

  function automatic reg_set_t rand_setting();
    reg_set_t s;
    int kind;
    kind = $urandom_range(0, 3);
    if (kind == 1) begin
      for (int i = 0; i < NumRegs; i++) begin
        case ($urandom_range(0, 4))
          0:       s[i] = 32'd0;
          1:       s[i] = 32'hFFFF_FFFF;
          2:       s[i] = PosMax;
          3:       s[i] = PosMin;
          default: s[i] = $urandom;
        endcase
      end
    end else if (kind == 2) begin
      for (int i = 0; i < NumRegs; i++) s[i] = $urandom;
    end else begin
      s[CfgInertiaStart] = $urandom_range(0, 32'h2_0000);
      s[CfgInertiaEnd]   = $urandom_range(0, 32'h1_0000);
      s[CfgMaxIter]      = $urandom_range(1, 200);
      s[CfgCognGain]     = $urandom_range(0, 32'h4_0000);
      s[CfgSocGain]      = $urandom_range(0, 32'h4_0000);
      s[CfgStepScale]    = $urandom_range(0, 32'h2_0000);
      s[CfgLowerLimit]   = -$urandom_range(0, 32'h4000_0000);
      s[CfgUpperLimit]   = $urandom_range(0, 32'h4000_0000);
      if (kind == 3) begin
        s[CfgLowerLimit] = PosMin;
        s[CfgUpperLimit] = PosMax;
      end
    end
    return s;
  endfunction

  task automatic run_random_phase(int count);
    drain_updates();
    apply_setting(rand_setting());
    idle_on = ($urandom_range(0, 3) != 0);
    repeat (count) begin
      send_update(gen_item(), 1'b0, '0);
      pace();
    end
  endtask

  always @(posedge clk_i) begin : result_check
    upd_res_t want;
    if (rst_ni && done_o) begin
      n_results++;
      act_seen[bound_action_o] = act_seen[bound_action_o] + 1;
      if (exp_updates.size() == 0) begin
        n_errors++;
        $display("%0t: result with no item pending, new_position %0d", $time,
                 new_position_o);
      end else begin
        want = exp_updates.pop_front();
        if (new_position_o !== want.pos) begin
          n_errors++;
          $display("%0t: new_position expected %0d got %0d", $time,
                   $signed(want.pos), new_position_o);
        end
        if (new_velocity_o !== want.vel) begin
          n_errors++;
          $display("%0t: new_velocity expected %0d got %0d", $time,
                   $signed(want.vel), new_velocity_o);
        end
        if (bound_action_o !== want.act) begin
          n_errors++;
          $display("%0t: bound_action expected %0d got %0d", $time, want.act,
                   bound_action_o);
        end
      end
    end
  end

  initial begin
    int cur_set;
    dir_row_t row;
    for (int i = 0; i < 4; i++) act_seen[i] = 0;

    // 0: reset values
    dir_set[0][CfgInertiaStart] = RstInertiaStart;
    dir_set[0][CfgInertiaEnd]   = RstInertiaEnd;
    dir_set[0][CfgMaxIter]      = RstMaxIter;
    dir_set[0][CfgCognGain]     = RstCognGain;
    dir_set[0][CfgSocGain]      = RstSocGain;
    dir_set[0][CfgStepScale]    = RstStepScale;
    dir_set[0][CfgLowerLimit]   = RstLowerLimit;
    dir_set[0][CfgUpperLimit]   = RstUpperLimit;
    // 1: zero iteration count, weight falls from 1.0 to 0
    dir_set[1] = dir_set[0];
    dir_set[1][CfgInertiaStart] = 32'h0001_0000;
    dir_set[1][CfgInertiaEnd]   = 32'd0;
    dir_set[1][CfgMaxIter]      = 32'd0;
    // 2: rising weight, limits reversed (upper -10.0 below lower 10.0)
    dir_set[2] = dir_set[0];
    dir_set[2][CfgInertiaStart] = 32'd0;
    dir_set[2][CfgInertiaEnd]   = PosMax;
    dir_set[2][CfgLowerLimit]   = 32'h000A_0000;
    dir_set[2][CfgUpperLimit]   = 32'hFFF6_0000;
    // 3: start, max count, gains and step at their top, unmasked bits set; range +-100.0
    dir_set[3][CfgInertiaStart] = 32'hFFFF_FFFF;
    dir_set[3][CfgInertiaEnd]   = 32'd0;
    dir_set[3][CfgMaxIter]      = 32'hFFFF_FFFF;
    dir_set[3][CfgCognGain]     = 32'hFFFF_FFFF;
    dir_set[3][CfgSocGain]      = 32'hFFFF_FFFF;
    dir_set[3][CfgStepScale]    = 32'hFFFF_FFFF;
    dir_set[3][CfgLowerLimit]   = 32'hFF9C_0000;
    dir_set[3][CfgUpperLimit]   = 32'h0064_0000;
    // 4: all zero
    dir_set[4] = '0;

    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                              1, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, PosMax, 0, PosMax, PosMax, 0, 16'h8000, 16'h8000, 16'h1234,
                              0, 1, PosMax, 0, ActNone));
    dir_rows.push_back(mk_row(0, PosMin, 0, PosMin, PosMin, 7, 16'h8000, 16'h8000, 16'h4321,
                              1, 1, PosMin, 0, ActNone));
    // re-seed from either bound, then shrink and clamp on both sides
    dir_rows.push_back(mk_row(0, PosMax, PosMax, PosMax, PosMax, 0, 0, 0, 16'h8000, 0,
                              0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, PosMin, PosMin, PosMin, PosMin, 0, 0, 0, 16'hFFFF, 1,
                              0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 32'h7FFF_0000, PosMax, PosMax, PosMax, 10, 16'h4000,
                              16'h4000, 16'hC000, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 32'h7FFF_0000, PosMax, PosMax, PosMax, 10, 16'h4000,
                              16'h4000, 16'hC000, 1, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 32'h8001_0000, PosMin, PosMin, PosMin, 10, 16'h4000,
                              16'h4000, 16'h3000, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 32'h8001_0000, PosMin, PosMin, PosMin, 10, 16'h4000,
                              16'h4000, 16'h3000, 1, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, 0, 32'h0001_0000, PosMax, PosMin, 50, 16'hFFFF, 16'hFFFF,
                              0, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, PosMin, PosMax, PosMax, PosMax, 99, 16'hFFFF, 0, 16'hFFFF,
                              1, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(0, PosMax, PosMin, PosMin, PosMin, 100, 0, 16'hFFFF, 0, 0,
                              0, 0, 0, ActNone));
    // zero iteration count: weight 1.0 at iteration 0, 0 at 1, saturated beyond
    dir_rows.push_back(mk_row(1, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 0,
                              1, 32'h0003_0000, 32'h0002_0000, ActNone));
    dir_rows.push_back(mk_row(1, 32'h0001_0000, 32'h0002_0000, 0, 0, 1, 0, 0, 0, 0,
                              1, 32'h0001_0000, 0, ActNone));
    dir_rows.push_back(mk_row(1, 32'h0001_0000, 32'h0001_0000, 0, 0, 16'hFFFF, 0, 0, 0, 0,
                              0, 0, 0, ActNone));
    // reversed limits: upper test first
    dir_rows.push_back(mk_row(2, 0, 0, 0, 0, 50, 16'h1111, 16'h2222, 16'h9000, 0,
                              0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(2, 0, 0, 0, 0, 50, 16'h1111, 16'h2222, 16'h9000, 1,
                              1, 32'hFFF6_0000, 0, ActClamp));
    dir_rows.push_back(mk_row(2, 32'hFFF6_0000, PosMax, 32'hFFF6_0000, 32'hFFF6_0000, 200,
                              16'h7777, 16'h8888, 16'hA5A5, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(2, 32'hFFEC_0000, 0, 32'hFFEC_0000, 32'hFFEC_0000, 3, 0, 0,
                              0, 1, 1, 32'h000A_0000, 0, ActClamp));
    // old position outside the range, then at its centre
    dir_rows.push_back(mk_row(3, 32'h00C8_0000, 32'h0001_0000, PosMax, PosMax, 0, 16'h0100,
                              16'h0100, 16'h8000, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(3, 32'hFF38_0000, 32'hFFFF_0000, PosMin, PosMin, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(3, 0, PosMax, PosMin, PosMax, 16'h8000, 16'hFFFF, 16'h0001,
                              16'h5555, 1, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(4, 32'h1234_5678, PosMax, 32'hDEAD_BEEF, 32'h0BAD_F00D, 9,
                              16'hFFFF, 16'hFFFF, 16'hC3C3, 0, 0, 0, 0, ActNone));
    dir_rows.push_back(mk_row(4, 0, PosMin, PosMax, PosMin, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 0, 1, 0, 0, ActNone));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_check_all();

    cur_set = -1;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (int'(row.set) != cur_set) begin
        drain_updates();
        apply_setting(dir_set[row.set]);
        cur_set = row.set;
      end
      send_update(row.it, row.has_exp, row.res);
      pace();
    end

    repeat (6) run_random_phase(180);

    drain_updates();
    repeat (Latency + 8) @(posedge clk_i);

    $display("%0d items under %0d register settings, %0d results, %0d errors",
             n_items, n_settings, n_results, n_errors);
    $display("bound actions seen: none %0d, reseed %0d, shrink %0d, clamp %0d",
             act_seen[ActNone], act_seen[ActReseed], act_seen[ActShrink], act_seen[ActClamp]);
    if (n_errors == 0 && exp_updates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run did not finish, %0d results outstanding", $time, exp_updates.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### pso_particle_dimension_update_top.f
+incdir+rtl
rtl/psodu_pkg.sv
rtl/psodu_wdiv.sv
rtl/pso_particle_dimension_update_top.sv
dv/pso_particle_dimension_update_top_tb.sv
